/* rtl/zrbd_pkg.sv */
// Shared types and constants for the zero-run bitmap row decoder.
// No dependencies; imported by every module of the decoder.
package zrbd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = BYTE_W * WORD_BYTES;
    localparam int INDEX_W    = 10;
    localparam int CFG_W      = 17;
    localparam int AMT_W      = 4;

    // One classified item as handed from front to back.
    // is_lit = 1: data is a literal byte. is_lit = 0: data is a zero-run count.
    typedef struct packed {
        logic              is_lit;
        logic [BYTE_W-1:0] data;
        logic              stream_end;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0]  bitmap_word;
        logic [INDEX_W-1:0] word_index;
        logic               row_last;
        logic               row_error;
    } t_word;

endpackage

/* rtl/zrbd_front.sv */
// Front end: accepts compressed bytes, tracks the zero-marker state and
// classifies each item into a command for the queue. Depends on zrbd_pkg.
module zrbd_front import zrbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_stream_end,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    logic r_expect;
    logic n_expect;
    logic accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_expect         = r_expect;
        o_q_push         = 1'b0;
        o_q_cmd.is_lit   = 1'b0;
        o_q_cmd.data     = i_data_byte;
        o_q_cmd.stream_end = i_stream_end;
        if (accept) begin
            if (r_expect) begin
                // run count
                o_q_push = 1'b1;
                n_expect = 1'b0;
            end else if (i_data_byte != '0) begin
                o_q_push       = 1'b1;
                o_q_cmd.is_lit = 1'b1;
            end else if (i_stream_end) begin
                // marker at end of stream: empty run, then abort the row
                o_q_push = 1'b1;
            end else begin
                n_expect = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_expect <= 1'b0;
        end else begin
            r_expect <= n_expect;
        end
    end

endmodule

/* rtl/zrbd_fifo.sv */
// Two-entry command queue between the front and back ends.
// Depends on zrbd_pkg for the command type.
module zrbd_fifo import zrbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/zrbd_back.sv */
// Back end: writes literal bytes and zero runs into the row, packs words,
// and holds the output register. Depends on zrbd_pkg.
module zrbd_back import zrbd_pkg::*; #(
    parameter int MAX_CLUSTERS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_word            o_out
);

    localparam int MAX_BYTES = (MAX_CLUSTERS + 7) / 8;
    localparam int POS_RAW   = $clog2(MAX_BYTES + 1);
    localparam int POS_W     = (POS_RAW < AMT_W) ? AMT_W : POS_RAW;
    localparam int CC_W      = CFG_W + 1;

    logic [POS_W-1:0]  r_row_len;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [WORD_W-1:0] r_buf,    n_buf;
    logic              r_active, n_active;
    logic              r_is_lit, n_is_lit;
    logic [BYTE_W-1:0] r_byte,   n_byte;
    logic [BYTE_W-1:0] r_cnt,    n_cnt;
    logic              r_end,    n_end;
    logic              r_out_valid, n_out_valid;
    t_word             r_out,    n_out;

    logic [CC_W-1:0]   cc_clamp;
    logic [CC_W-1:0]   len_full;
    logic [2:0]        off;
    logic [AMT_W-1:0]  room_w;
    logic [POS_W-1:0]  room_r;
    logic [AMT_W-1:0]  amt_run;
    logic [AMT_W-1:0]  amt;
    logic [AMT_W-1:0]  step_amt;
    logic [POS_W-1:0]  new_pos;
    logic [POS_W-1:0]  last_pos;
    logic [WORD_W-1:0] lit_word;
    logic [WORD_W-1:0] buf_new;
    logic              row_done;
    logic              word_full;
    logic              out_free;
    logic [BYTE_W-1:0] rem;

    // row length in bytes from the written cluster count
    always_comb begin
        if (i_cfg_data == '0) begin
            cc_clamp = CC_W'(1);
        end else if (CC_W'(i_cfg_data) > CC_W'(MAX_CLUSTERS)) begin
            cc_clamp = CC_W'(MAX_CLUSTERS);
        end else begin
            cc_clamp = CC_W'(i_cfg_data);
        end
        len_full = (cc_clamp + CC_W'(7)) >> 3;
    end

    // zero runs advance up to the next word or row boundary, or the run's end, in one step
    always_comb begin
        off     = r_pos[2:0];
        room_w  = AMT_W'(WORD_BYTES) - {1'b0, off};
        room_r  = r_row_len - r_pos;
        amt_run = (r_cnt < BYTE_W'(room_w)) ? r_cnt[AMT_W-1:0] : room_w;
        amt     = (room_r < POS_W'(amt_run)) ? room_r[AMT_W-1:0] : amt_run;
        step_amt = r_is_lit ? AMT_W'(1) : amt;
        new_pos  = r_pos + POS_W'(step_amt);
        last_pos = new_pos - POS_W'(1);
        lit_word = WORD_W'(r_byte) << {off, 3'b000};
        buf_new  = r_is_lit ? (r_buf | lit_word) : r_buf;
        row_done = (new_pos >= r_row_len);
        word_full = (new_pos[2:0] == 3'd0);
        rem      = r_is_lit ? '0 : (r_cnt - BYTE_W'(amt));
        out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_pos       = r_pos;
        n_buf       = r_buf;
        n_active    = r_active;
        n_is_lit    = r_is_lit;
        n_byte      = r_byte;
        n_cnt       = r_cnt;
        n_end       = r_end;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;

        if (!r_active) begin
            o_q_pop = i_q_valid;
        end else if (r_is_lit || r_cnt != '0) begin
            if (!(row_done || word_full) || out_free) begin
                n_pos    = new_pos;
                n_buf    = buf_new;
                n_cnt    = rem;
                n_is_lit = 1'b0;
                if (row_done) begin
                    n_out_valid       = 1'b1;
                    n_out.bitmap_word = buf_new;
                    n_out.word_index  = INDEX_W'(last_pos >> 3);
                    n_out.row_last    = 1'b1;
                    n_out.row_error   = 1'b0;
                    n_pos    = '0;
                    n_buf    = '0;
                    n_active = 1'b0;
                    o_q_pop  = i_q_valid;
                end else begin
                    if (word_full) begin
                        n_out_valid       = 1'b1;
                        n_out.bitmap_word = buf_new;
                        n_out.word_index  = INDEX_W'(last_pos >> 3);
                        n_out.row_last    = 1'b0;
                        n_out.row_error   = 1'b0;
                        n_buf             = '0;
                    end
                    if (rem == '0 && !r_end) begin
                        n_active = 1'b0;
                        o_q_pop  = i_q_valid;
                    end
                end
            end
        end else if (r_end) begin
            // stream ran out before the row filled: flush partial word
            if (out_free) begin
                n_out_valid       = 1'b1;
                n_out.bitmap_word = r_buf;
                n_out.word_index  = INDEX_W'(r_pos >> 3);
                n_out.row_last    = 1'b1;
                n_out.row_error   = 1'b1;
                n_pos    = '0;
                n_buf    = '0;
                n_active = 1'b0;
                o_q_pop  = i_q_valid;
            end
        end else begin
            n_active = 1'b0;
            o_q_pop  = i_q_valid;
        end

        if (o_q_pop) begin
            n_active = 1'b1;
            n_is_lit = i_q_cmd.is_lit;
            n_byte   = i_q_cmd.data;
            n_cnt    = i_q_cmd.is_lit ? '0 : i_q_cmd.data;
            n_end    = i_q_cmd.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len   <= POS_W'(1);
            r_pos       <= '0;
            r_buf       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_row_len   <= POS_W'(len_full);
            r_pos       <= '0;
            r_buf       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= n_out_valid;
        end else begin
            r_pos       <= n_pos;
            r_buf       <= n_buf;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_lit <= n_is_lit;
        r_byte   <= n_byte;
        r_cnt    <= n_cnt;
        r_end    <= n_end;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/zero_run_bitmap_decoder.sv */
// Path: an accepted literal byte passes the command queue, the back-end command registers
//   and the output register. Throughput: one literal or marker byte per cycle while no zero
//   run is being written and the output is not stalled; a zero run is written in steps that
//   each end at a word or row boundary or at the run's end; an early stream end adds a flush step.
// Reset (i_rst_n, synchronous, active low) clears the row state and queue;
//   cluster_count returns to 1. A register write also starts a new row.
module zero_run_bitmap_decoder import zrbd_pkg::*; #(
    parameter int MAX_CLUSTERS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_stream_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WORD_W-1:0]  o_bitmap_word,
    output logic [INDEX_W-1:0] o_word_index,
    output logic               o_row_last,
    output logic               o_row_error
);

    logic  q_full;
    logic  q_push;
    t_cmd  q_in_cmd;
    logic  q_pop;
    logic  q_valid;
    t_cmd  q_out_cmd;
    t_word out_word;

    zrbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd)
    );

    zrbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    zrbd_back #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (out_word)
    );

    assign o_bitmap_word = out_word.bitmap_word;
    assign o_word_index  = out_word.word_index;
    assign o_row_last    = out_word.row_last;
    assign o_row_error   = out_word.row_error;

endmodule

/* dv/zero_run_bitmap_decoder_test.sv */
// Self-checking bench for zero_run_bitmap_decoder: directed and random compressed rows,
// decoded in-bench and compared word by word under random stalls on both handshakes.
// Depends on zrbd_pkg and the zero_run_bitmap_decoder RTL.
module zero_run_bitmap_decoder_test;
    import zrbd_pkg::*;

    localparam int unsigned CLUSTER_CAP  = 65536;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned RANDOM_ITEMS = 260;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [BYTE_W-1:0] ZERO_MARKER = 8'd0;
    localparam logic [BYTE_W-1:0] FULL_RUN    = 8'd255;

    typedef enum int {ROW_FULL, ROW_CUT, ROW_CUT_AT_MARKER} t_row_end;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [BYTE_W-1:0]  i_data_byte = '0;
    logic               i_stream_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [WORD_W-1:0]  o_bitmap_word;
    logic [INDEX_W-1:0] o_word_index;
    logic               o_row_last;
    logic               o_row_error;

    // decoder state mirrored in the bench
    logic [CFG_W-1:0]  cluster_cfg = 17'd1;
    logic [13:0]       row_pos = '0;
    bit                run_pending = 1'b0;
    logic [WORD_W-1:0] word_acc = '0;
    t_word             expected_words[$];

    int unsigned rows_finished = 0;
    int unsigned items_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_cycles = 0;
    bit          gaps_off = 1'b0;

    zero_run_bitmap_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_stream_end  (i_stream_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bitmap_word (o_bitmap_word),
        .o_word_index  (o_word_index),
        .o_row_last    (o_row_last),
        .o_row_error   (o_row_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned row_bytes();
        int unsigned clusters;
        clusters = cluster_cfg;
        if (clusters == 0) clusters = 1;
        if (clusters > CLUSTER_CAP) clusters = CLUSTER_CAP;
        return (clusters + 7) >> 3;
    endfunction

    function automatic void clear_row();
        row_pos = '0;
        run_pending = 1'b0;
        word_acc = '0;
    endfunction

    function automatic void push_word(input int unsigned word_no, input logic last,
                                      input logic err);
        t_word w;
        w.bitmap_word = word_acc;
        w.word_index = INDEX_W'(word_no);
        w.row_last = last;
        w.row_error = err;
        expected_words = {expected_words, w};
        if (last) rows_finished++;
    endfunction

    // Returns 1 when this byte completes the row.
    function automatic bit place_byte(input logic [BYTE_W-1:0] b);
        word_acc |= {56'd0, b} << (8 * row_pos[2:0]);
        row_pos++;
        if (row_pos >= row_bytes()) begin
            push_word((row_pos - 1) >> 3, 1'b1, 1'b0);
            clear_row();
            return 1'b1;
        end
        if (row_pos[2:0] == 3'd0) begin
            push_word((row_pos - 1) >> 3, 1'b0, 1'b0);
            word_acc = '0;
        end
        return 1'b0;
    endfunction

    function automatic void decode_item(input logic [BYTE_W-1:0] b, input logic last_byte);
        bit done;
        done = 1'b0;
        if (run_pending) begin
            run_pending = 1'b0;
            for (int k = 0; k < b && !done; k++) done = place_byte(ZERO_MARKER);
        end else if (b != ZERO_MARKER) begin
            done = place_byte(b);
        end else begin
            run_pending = 1'b1;
        end
        // stream ran out before the row filled: flush partial word as an error
        if (last_byte && !done) begin
            push_word(row_pos >> 3, 1'b1, 1'b1);
            clear_row();
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return 0;
            12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            default: return $urandom_range(8, 30);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] run_length();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return FULL_RUN;
            2, 3: return BYTE_W'($urandom_range(8, 64));
            default: return BYTE_W'($urandom_range(1, 7));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_byte);
        int unsigned gap;
        gap = gaps_off ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_stream_end <= last_byte;
        do @(posedge i_clk); while (!o_in_ready);
        decode_item(b, last_byte);
        items_sent++;
    endtask

    task automatic send_run(input logic [BYTE_W-1:0] count, input logic last_byte);
        send_byte(ZERO_MARKER, 1'b0);
        send_byte(count, last_byte);
    endtask

    // Drop valid, wait for every expected word, then let in-flight items drain.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_stream_end <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cluster_count(input logic [CFG_W-1:0] value);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cluster_cfg = value;
        clear_row();
    endtask

    task automatic gen_row();
        int unsigned start_rows, n, cut;
        t_row_end ending;
        start_rows = rows_finished;
        case ($urandom_range(0, 9))
            0, 1: ending = ROW_CUT;
            2: ending = ROW_CUT_AT_MARKER;
            default: ending = ROW_FULL;
        endcase
        cut = $urandom_range(1, 16);
        n = 0;
        while (rows_finished == start_rows) begin
            n++;
            if (ending != ROW_FULL && n >= cut) begin
                if (ending == ROW_CUT_AT_MARKER) send_byte(ZERO_MARKER, 1'b1);
                else send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end else if ($urandom_range(0, 1) == 1) begin
                send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
            end else begin
                send_run(run_length(), 1'b0);
            end
        end
    endtask

    // reset value of the register: one-byte rows
    task automatic test_default_row_length();
        send_byte(8'hFF, 1'b0);
        send_run(8'd7, 1'b0);           // clipped to the single byte
        send_byte(ZERO_MARKER, 1'b1);   // stream ends right after a marker
        send_run(8'd0, 1'b1);
    endtask

    task automatic test_count_limits();
        write_cluster_count(17'd0);
        send_byte(8'h5A, 1'b0);
        write_cluster_count('1);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_runs_and_literals();
        write_cluster_count(17'd100);   // 13-byte row
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_run(8'd0, 1'b0);
        send_run(8'd3, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_run(FULL_RUN, 1'b0);
        send_run(8'd9, 1'b1);
        send_run(8'd12, 1'b0);
        send_byte(8'h33, 1'b1);         // end flag on the byte that fills the row
    endtask

    task automatic test_full_length_row();
        int unsigned start_rows;
        write_cluster_count(17'(CLUSTER_CAP));
        start_rows = rows_finished;
        while (rows_finished == start_rows) send_run(FULL_RUN, 1'b0);
        write_cluster_count(17'(CLUSTER_CAP + 1));
        repeat (20) send_run(FULL_RUN, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_output_stall();
        write_cluster_count(17'd2048);
        gaps_off = 1'b1;
        hold_cycles = 400;
        repeat (8) send_run(FULL_RUN, 1'b0);
        repeat (2) gen_row();
        gaps_off = 1'b0;
    endtask

    task automatic test_random_rows();
        int unsigned first_item;
        logic [CFG_W-1:0] clusters;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: clusters = CFG_W'($urandom_range(0, 16));
                1, 2, 3, 4, 5: clusters = CFG_W'($urandom_range(1, 128));
                6, 7, 8: clusters = CFG_W'($urandom_range(129, 1024));
                default: clusters = CFG_W'($urandom_range(1025, 4096));
            endcase
            write_cluster_count(clusters);
            gaps_off = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 7) == 0) begin
                    // unstructured bytes with stray end flags
                    repeat ($urandom_range(10, 30))
                        send_byte(($urandom_range(0, 3) == 0) ? ZERO_MARKER
                                  : BYTE_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 9) == 0);
                end else begin
                    gen_row();
                end
            end
        end
        gaps_off = 1'b0;
    endtask

    initial begin : out_ready_gen
        int unsigned span;
        logic level;
        span = 0;
        level = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                if (span == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin
                            level = 1'b1;
                            span = $urandom_range(10, 40);
                        end
                        3, 4, 5, 6: begin
                            level = 1'b1;
                            span = $urandom_range(1, 4);
                        end
                        7, 8: begin
                            level = 1'b0;
                            span = $urandom_range(1, 3);
                        end
                        default: begin
                            level = 1'b0;
                            span = $urandom_range(10, 40);
                        end
                    endcase
                end
                i_out_ready <= level;
                span--;
            end
        end
    end

    always @(posedge i_clk) begin : word_check
        t_word got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.bitmap_word = o_bitmap_word;
            got.word_index = o_word_index;
            got.row_last = o_row_last;
            got.row_error = o_row_error;
            if (expected_words.size() == 0) begin
                note_failure($sformatf("unexpected word %h index %0d last %b error %b",
                             got.bitmap_word, got.word_index, got.row_last, got.row_error));
            end else begin
                want = expected_words.pop_front();
                if (got.bitmap_word !== want.bitmap_word || got.word_index !== want.word_index
                    || got.row_last !== want.row_last || got.row_error !== want.row_error)
                    note_failure($sformatf("expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.bitmap_word, want.word_index, want.row_last,
                                 want.row_error, got.bitmap_word, got.word_index,
                                 got.row_last, got.row_error));
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_row_length();
        test_count_limits();
        test_runs_and_literals();
        test_full_length_row();
        test_output_stall();
        test_random_rows();
        settle();
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
